// File: rtl/cbs_pkg.sv
// Shared types, constants and register codes for the CAN broadcast segmenter.
`timescale 1ns / 1ps
package cbs_pkg;

    localparam int unsigned BYTES_PER_FRAME = 7;
    localparam logic [10:0] MAX_LENGTH      = 11'd1785;
    localparam logic [7:0]  CTRL_BAM        = 8'h20;
    localparam logic [7:0]  RESERVED_BYTE   = 8'hFF;

    // Reciprocal of 7 over 2^14, exact for the floor of any 12-bit numerator
    localparam logic [13:0] RECIP_SEVEN     = 14'd2341;
    localparam int unsigned RECIP_SHIFT     = 14;

    localparam logic [2:0]  PRIORITY_RESET  = 3'd1;
    localparam logic [17:0] HEADER_RESET    = 18'd60416;
    localparam logic [17:0] DATA_RESET      = 18'd60160;
    localparam logic [23:0] CONTENT_RESET   = 24'd0;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    typedef enum logic [1:0] {
        REG_PRIORITY = 2'd0,
        REG_HEADER   = 2'd1,
        REG_DATA     = 2'd2,
        REG_CONTENT  = 2'd3
    } cbs_reg_e;

    typedef struct packed {
        logic        cmd;
        logic [10:0] total_length;
        logic [7:0]  data_byte;
    } cbs_in_t;

    typedef struct packed {
        logic [28:0] frame_id;
        logic [3:0]  frame_len;
        logic [63:0] payload;
        logic        is_header;
    } cbs_out_t;

    // Control shared by every byte cell of the chain
    typedef struct packed {
        logic clear;
        logic shift;
    } cbs_cell_ctl_t;

endpackage

// File: rtl/can_broadcast_segmenter.sv
// Top level of the CAN broadcast segmenter: header build, byte chain and frame register.
`timescale 1ns / 1ps
// Takes one item per clock: a start item (cmd 0) yields the announcement header frame,
// data items (cmd 1) fill a chain of seven byte cells, and the seventh byte or the last
// announced byte yields a data frame with its sequence number. Each frame shows up in the
// frame register on the cycle after its item; the input stalls only while that register
// holds a frame the receiver is stalling, so with no output stall the block runs at one
// item per cycle. Lengths above 1785 are taken as 1785, data with no open message and a
// message abandoned by a new start produce no frame. Configuration writes are registered before use.
module can_broadcast_segmenter (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [23:0]      cfg_data,
    input  logic             item_valid,
    output logic             item_stall,
    input  cbs_pkg::cbs_in_t item,
    output logic             frame_valid,
    input  logic             frame_stall,
    output cbs_pkg::cbs_out_t frame
);
    import cbs_pkg::*;

    localparam int unsigned NCELL = BYTES_PER_FRAME;

    // configuration
    logic [2:0]  priority_reg, priority_next;
    logic [17:0] header_group_reg, header_group_next;
    logic [17:0] data_group_reg, data_group_next;
    logic [23:0] content_group_reg, content_group_next;

    // message state
    logic [10:0] message_length_reg, message_length_next;
    logic [10:0] bytes_taken_reg, bytes_taken_next;
    logic [2:0]  fill_count_reg, fill_count_next;
    logic [7:0]  sequence_reg, sequence_next;
    logic        active_reg, active_next;

    // output stage
    logic        frame_valid_reg, frame_valid_next;
    cbs_out_t    frame_reg, frame_next;

    logic        accept;
    logic        start_acc;
    logic        take;
    logic [10:0] taken_inc;
    logic        last_byte;
    logic        full_frame;
    logic        flush;
    logic [10:0] len_sat;
    logic [11:0] len_round;
    logic [25:0] pkt_prod;
    logic [7:0]  packets;
    logic [63:0] header_payload;
    logic [55:0] data_bytes;

    cbs_cell_ctl_t        cell_ctl;
    logic [NCELL-1:0]     token_vec;
    logic [NCELL-1:0][7:0] byte_vec;

    assign item_stall = frame_valid_reg && frame_stall;
    assign accept     = item_valid && !item_stall;
    assign start_acc  = accept && (item.cmd == CMD_START);
    assign take       = accept && (item.cmd == CMD_DATA) && active_reg;

    assign taken_inc  = bytes_taken_reg + 11'd1;
    assign last_byte  = taken_inc >= message_length_reg;
    assign full_frame = fill_count_reg == 3'(NCELL - 1);
    assign flush      = take && (full_frame || last_byte);

    // Header fields
    assign len_sat   = (item.total_length > MAX_LENGTH) ? MAX_LENGTH : item.total_length;
    assign len_round = {1'b0, len_sat} + 12'(NCELL - 1);
    assign pkt_prod  = len_round * RECIP_SEVEN;
    assign packets   = pkt_prod[RECIP_SHIFT +: 8];

    assign header_payload = {content_group_reg[7:0], content_group_reg[15:8],
                             content_group_reg[23:16], RESERVED_BYTE, packets,
                             len_sat[7:0], {5'b0, len_sat[10:8]}, CTRL_BAM};

    // Byte chain
    assign cell_ctl.clear = start_acc || flush;
    assign cell_ctl.shift = take;

    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++)
        begin : g_cell
            cbs_byte_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (cell_ctl),
                .seed      (gi == 0),
                .token_in  ((gi == 0) ? 1'b0 : token_vec[(gi == 0) ? 0 : gi - 1]),
                .data_in   (item.data_byte),
                .token_out (token_vec[gi]),
                .byte_view (byte_vec[gi])
            );
        end
    endgenerate

    assign data_bytes = byte_vec;

    always_comb
    begin
        priority_next      = priority_reg;
        header_group_next  = header_group_reg;
        data_group_next    = data_group_reg;
        content_group_next = content_group_reg;
        if (cfg_we)
        begin
            case (cbs_reg_e'(cfg_index))
                REG_PRIORITY: priority_next      = cfg_data[2:0];
                REG_HEADER:   header_group_next  = cfg_data[17:0];
                REG_DATA:     data_group_next    = cfg_data[17:0];
                REG_CONTENT:  content_group_next = cfg_data;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        message_length_next = message_length_reg;
        bytes_taken_next    = bytes_taken_reg;
        fill_count_next     = fill_count_reg;
        sequence_next       = sequence_reg;
        active_next         = active_reg;
        if (start_acc)
        begin
            message_length_next = len_sat;
            bytes_taken_next    = 11'd0;
            fill_count_next     = 3'd0;
            sequence_next       = 8'd1;
            active_next         = len_sat != 11'd0;
        end
        else if (take)
        begin
            bytes_taken_next = taken_inc;
            fill_count_next  = flush ? 3'd0 : fill_count_reg + 3'd1;
            if (flush)
            begin
                sequence_next = sequence_reg + 8'd1;
            end
            if (last_byte)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        frame_next       = frame_reg;
        frame_valid_next = frame_valid_reg && frame_stall;
        if (start_acc)
        begin
            frame_valid_next     = 1'b1;
            frame_next.frame_id  = {priority_reg, header_group_reg, 8'h00};
            frame_next.frame_len = 4'd8;
            frame_next.payload   = header_payload;
            frame_next.is_header = 1'b1;
        end
        else if (flush)
        begin
            frame_valid_next     = 1'b1;
            frame_next.frame_id  = {priority_reg, data_group_reg, 8'h00};
            frame_next.frame_len = {1'b0, fill_count_reg} + 4'd2;
            frame_next.payload   = {data_bytes, sequence_reg};
            frame_next.is_header = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            priority_reg       <= PRIORITY_RESET;
            header_group_reg   <= HEADER_RESET;
            data_group_reg     <= DATA_RESET;
            content_group_reg  <= CONTENT_RESET;
            message_length_reg <= 11'd0;
            bytes_taken_reg    <= 11'd0;
            fill_count_reg     <= 3'd0;
            sequence_reg       <= 8'd0;
            active_reg         <= 1'b0;
            frame_valid_reg    <= 1'b0;
        end
        else
        begin
            priority_reg       <= priority_next;
            header_group_reg   <= header_group_next;
            data_group_reg     <= data_group_next;
            content_group_reg  <= content_group_next;
            message_length_reg <= message_length_next;
            bytes_taken_reg    <= bytes_taken_next;
            fill_count_reg     <= fill_count_next;
            sequence_reg       <= sequence_next;
            active_reg         <= active_next;
            frame_valid_reg    <= frame_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

`ifndef SYNTH
    // The write token sits at the cell the fill count names
    a_token_pos: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (token_vec == (NCELL'(1) << fill_count_reg)))
        else $error("byte chain token out of step with fill count");

    a_open_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (bytes_taken_reg < message_length_reg))
        else $error("open message has taken all its bytes");

    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (fill_count_reg == 3'd0))
        else $error("bytes pending with no open message");

    a_start_header: assert property (@(posedge clk) disable iff (!rst_n)
        start_acc |=> (frame_valid_reg && frame_reg.is_header))
        else $error("start item did not yield a header frame");
`endif

endmodule

// File: rtl/cbs_byte_cell.sv
// One byte slot of the data frame, with the write token passed along the chain.
`timescale 1ns / 1ps
module cbs_byte_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cbs_pkg::cbs_cell_ctl_t ctl,
    input  logic                  seed,
    input  logic                  token_in,
    input  logic [7:0]            data_in,
    output logic                  token_out,
    output logic [7:0]            byte_view
);
    import cbs_pkg::*;

    logic       token_reg;
    logic       token_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       write_here;

    assign write_here = ctl.shift && token_reg;

    always_comb
    begin
        if (ctl.clear)
        begin
            token_next = seed;
        end
        else if (ctl.shift)
        begin
            token_next = token_in;
        end
        else
        begin
            token_next = token_reg;
        end
    end

    always_comb
    begin
        if (ctl.clear)
        begin
            byte_next = 8'h00;
        end
        else if (write_here)
        begin
            byte_next = data_in;
        end
        else
        begin
            byte_next = byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= 1'b0;
        end
        else
        begin
            token_reg <= token_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    // The arriving byte shows through at once so a closing frame includes it
    assign byte_view = write_here ? data_in : byte_reg;
    assign token_out = token_reg;

endmodule
